[rtl/core/sts_pkg.sv]
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants of the sphere triangle subdivision block.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int INDEX_BITS_DEF = 20;
  localparam int COORD_BITS_DEF = 24;
  localparam int RADIUS_BITS    = 23;
  localparam int VERTS_OUT      = 12;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 23'd65536;
  localparam logic [0:0] REG_SPHERE_RADIUS = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_SQ,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_DONE,
    ST_EMIT
  } state_t;

endpackage

[rtl/core/sts_chan_if.sv]
// ----------------------------------------------------------------------------
// sts_chan_if
// Valid/ready channel carrying one payload of a parameterized width.
// ----------------------------------------------------------------------------
interface sts_chan_if #(
  parameter int WIDTH = 8
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/sphere_triangle_subdivide.sv]
// ----------------------------------------------------------------------------
// sphere_triangle_subdivide
// Splits one triangle into four, projecting edge midpoints onto a sphere.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in      | in  | first/second/third xyz, level_start (LSB)
//  out     | out | out_x, out_y, out_z, vertex_number, last_of_triangle,
//          |     | degenerate (LSB)
//  cfg     | in  | APB write/read of sphere_radius at address 0
//
// The bit-serial square root and the restoring divider handle one result bit
// per cycle. A zero-length edge skips its root and divisions. Results leave
// through one output register; a stalled sink holds the block in its emit
// step. Reset is synchronous, active low, clears the control state and loads
// sphere_radius with its reset value 65536.
// ----------------------------------------------------------------------------
module sphere_triangle_subdivide #(
  parameter int INDEX_BITS = sts_pkg::INDEX_BITS_DEF,
  parameter int COORD_BITS = sts_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sts_chan_if.sink    in_chan,
  sts_chan_if.source  out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int C   = COORD_BITS;
  localparam int SW  = C + 1;              // edge sum width (signed)
  localparam int QW  = 2 * SW + 2;         // squared length width
  localparam int RB  = (QW + 1) / 2;       // root bits
  localparam int NW  = SW + sts_pkg::RADIUS_BITS; // numerator width
  localparam int QB  = NW;                 // quotient bits
  localparam int CNW = $clog2(QB + 1);

  // ---------------- configuration ----------------
  logic [sts_pkg::RADIUS_BITS-1:0] radius_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= sts_pkg::RADIUS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[1:0] == {sts_pkg::REG_SPHERE_RADIUS, 1'b0}) begin
      radius_r <= cfg_pwdata[sts_pkg::RADIUS_BITS-1:0];
    end
  end
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ?
                      {{(32-sts_pkg::RADIUS_BITS){1'b0}}, radius_r} : 32'd0;

  // ---------------- data registers ----------------
  sts_pkg::state_t state_r, state_nxt;
  logic signed [C-1:0] v_r [3][3];
  logic signed [C-1:0] m_r [3][3];
  logic [2:0]          mdeg_r;
  logic                lvl_r;
  logic [1:0]          edge_r;   // 0: first+second, 1: second+third, 2: first+third
  logic [1:0]          comp_r;
  logic signed [SW-1:0] s_r [3];
  logic [QW-1:0]       q_r;
  logic [RB-1:0]       root_r;
  logic [CNW-1:0]      cnt_r;
  logic [NW-1:0]       num_r;
  logic [NW:0]         rem_r;
  logic [QB-1:0]       quo_r;
  logic [3:0]          k_r;
  logic [INDEX_BITS-1:0] idx_r;

  // output register
  logic                out_valid_r;
  logic signed [C-1:0] ox_r, oy_r, oz_r;
  logic [INDEX_BITS-1:0] onum_r;
  logic                olast_r, odeg_r;

  assign in_chan.ready  = (state_r == sts_pkg::ST_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = {ox_r, oy_r, oz_r, onum_r, olast_r, odeg_r};

  wire in_fire  = in_chan.valid && in_chan.ready;
  wire out_free = !out_valid_r || out_chan.ready;

  // edge end points
  logic [1:0] ea, eb;
  always_comb begin
    case (edge_r)
      2'd0:    begin ea = 2'd0; eb = 2'd1; end
      2'd1:    begin ea = 2'd1; eb = 2'd2; end
      default: begin ea = 2'd0; eb = 2'd2; end
    endcase
  end

  // multiplier: |s|*R in ST_DIV_INIT (ST_SQ accumulates sq_full instead)
  logic [SW-1:0] mag_s;
  logic [NW-1:0] prod;
  always_comb begin
    mag_s = s_r[comp_r][SW-1] ? SW'(-s_r[comp_r]) : SW'(s_r[comp_r]);
    if (state_r == sts_pkg::ST_SQ) begin
      prod = NW'(mag_s * mag_s);
    end else begin
      prod = NW'(mag_s * radius_r);
    end
  end
  wire [QW-1:0] sq_full = QW'(mag_s) * QW'(mag_s);

  // square root trial
  wire [RB-1:0] trial = root_r | (RB'(1) << cnt_r);
  wire [2*RB-1:0] trial_sq = (2*RB)'(trial) * (2*RB)'(trial);
  // divider step
  wire [NW:0] rem_sh = {rem_r[NW-1:0], num_r[NW-1]};
  wire [NW:0] len_ext = (NW+1)'(root_r);
  wire        dge = rem_sh >= len_ext;

  // saturation of the quotient
  localparam logic [QB-1:0] MAXP = QB'((64'd1 << (C-1)) - 64'd1);
  logic signed [C-1:0] sat;
  always_comb begin
    if (s_r[comp_r][SW-1]) begin
      sat = (quo_r > MAXP) ? {1'b1, {(C-1){1'b0}}} : C'(-$signed({1'b0, quo_r}));
    end else begin
      sat = (quo_r > MAXP) ? {1'b0, {(C-1){1'b1}}} : C'(quo_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sts_pkg::ST_IDLE:     if (in_fire) state_nxt = sts_pkg::ST_SUM;
      sts_pkg::ST_SUM:      state_nxt = sts_pkg::ST_SQ;
      sts_pkg::ST_SQ: begin
        if (comp_r == 2'd2) begin
          state_nxt = sts_pkg::ST_SQRT;
        end
      end
      sts_pkg::ST_SQRT: begin
        if (q_r == '0) begin
          state_nxt = (edge_r == 2'd2) ? sts_pkg::ST_EMIT : sts_pkg::ST_SUM;
        end else if (cnt_r == '0) begin
          state_nxt = sts_pkg::ST_DIV_INIT;
        end
      end
      sts_pkg::ST_DIV_INIT: state_nxt = sts_pkg::ST_DIV;
      sts_pkg::ST_DIV:      if (cnt_r == '0) state_nxt = sts_pkg::ST_DIV_DONE;
      sts_pkg::ST_DIV_DONE: begin
        if (comp_r != 2'd2) begin
          state_nxt = sts_pkg::ST_DIV_INIT;
        end else begin
          state_nxt = (edge_r == 2'd2) ? sts_pkg::ST_EMIT : sts_pkg::ST_SUM;
        end
      end
      sts_pkg::ST_EMIT: begin
        if (out_free && k_r == 4'(sts_pkg::VERTS_OUT - 1)) state_nxt = sts_pkg::ST_IDLE;
      end
      default: state_nxt = sts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sts_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // emit selection: which vertex goes out at step k
  logic        sel_mid;
  logic [1:0]  sel_i;
  always_comb begin
    sel_mid = 1'b1;
    sel_i   = 2'd0;
    case (k_r)
      4'd0:  begin sel_mid = 1'b0; sel_i = 2'd0; end
      4'd1, 4'd3, 4'd6: sel_i = 2'd0;
      4'd2, 4'd8, 4'd9: sel_i = 2'd2;
      4'd4:  begin sel_mid = 1'b0; sel_i = 2'd1; end
      4'd5, 4'd7, 4'd10: sel_i = 2'd1;
      4'd11: begin sel_mid = 1'b0; sel_i = 2'd2; end
      default: sel_i = 2'd0;
    endcase
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      edge_r      <= '0;
      comp_r      <= '0;
      k_r         <= '0;
      cnt_r       <= '0;
    end else begin
      if (state_r == sts_pkg::ST_EMIT && out_free) out_valid_r <= 1'b1;
      else if (out_chan.ready)                      out_valid_r <= 1'b0;
      case (state_r)
        sts_pkg::ST_IDLE: begin
          if (in_fire) begin
            for (int i = 0; i < 3; i++) begin
              for (int j = 0; j < 3; j++) begin
                v_r[i][j] <= in_chan.data[1 + (8-3*i-j)*C +: C];
              end
            end
            lvl_r  <= in_chan.data[0];
            edge_r <= 2'd0;
            k_r    <= '0;
          end
        end
        sts_pkg::ST_SUM: begin
          for (int j = 0; j < 3; j++) begin
            s_r[j] <= SW'(v_r[ea][j]) + SW'(v_r[eb][j]);
          end
          comp_r <= 2'd0;
          q_r    <= '0;
        end
        sts_pkg::ST_SQ: begin
          q_r    <= q_r + sq_full;
          comp_r <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
          root_r <= '0;
          cnt_r  <= CNW'(RB - 1);
        end
        sts_pkg::ST_SQRT: begin
          if (q_r == '0) begin
            for (int j = 0; j < 3; j++) m_r[edge_r][j] <= '0;
            mdeg_r[edge_r] <= 1'b1;
            edge_r <= edge_r + 2'd1;
          end else begin
            if (trial_sq <= (2*RB)'(q_r)) root_r <= trial;
            if (cnt_r != '0) cnt_r <= cnt_r - 1'b1;
          end
        end
        sts_pkg::ST_DIV_INIT: begin
          num_r <= prod + NW'(root_r >> 1);
          rem_r <= '0;
          quo_r <= '0;
          cnt_r <= CNW'(QB - 1);
        end
        sts_pkg::ST_DIV: begin
          num_r <= {num_r[NW-2:0], 1'b0};
          rem_r <= dge ? rem_sh - len_ext : rem_sh;
          quo_r <= {quo_r[QB-2:0], dge};
          if (cnt_r != '0) cnt_r <= cnt_r - 1'b1;
        end
        sts_pkg::ST_DIV_DONE: begin
          m_r[edge_r][comp_r] <= sat;
          mdeg_r[edge_r] <= 1'b0;
          if (comp_r == 2'd2) begin
            comp_r <= 2'd0;
            edge_r <= edge_r + 2'd1;
          end else begin
            comp_r <= comp_r + 2'd1;
          end
        end
        sts_pkg::ST_EMIT: begin
          if (out_free) begin
            ox_r <= sel_mid ? m_r[sel_i][0] : v_r[sel_i][0];
            oy_r <= sel_mid ? m_r[sel_i][1] : v_r[sel_i][1];
            oz_r <= sel_mid ? m_r[sel_i][2] : v_r[sel_i][2];
            odeg_r  <= sel_mid ? mdeg_r[sel_i] : 1'b0;
            olast_r <= (k_r == 4'(sts_pkg::VERTS_OUT - 1));
            if (k_r == '0 && lvl_r) begin
              onum_r <= '0;
              idx_r  <= INDEX_BITS'(1);
            end else begin
              onum_r <= idx_r;
              idx_r  <= idx_r + 1'b1;
            end
            k_r <= k_r + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[test/tb_sphere_triangle_subdivide.sv]
// ----------------------------------------------------------------------------
// tb_sphere_triangle_subdivide
// Sends triangles into the subdivision block, predicts the twelve vertices of
// each one and compares every result beat field by field.
// ----------------------------------------------------------------------------
module tb_sphere_triangle_subdivide;

  localparam int CB = sts_pkg::COORD_BITS_DEF;
  localparam int IB = sts_pkg::INDEX_BITS_DEF;
  localparam int IN_W = 9 * CB + 1;
  localparam int OUT_W = 3 * CB + IB + 2;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic [IB-1:0]        number;
    logic                 last;
    logic                 degen;
  } vertex_t;

  typedef struct {
    longint c[3];
    bit     degen;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  sts_chan_if #(.WIDTH(IN_W)) in_chan ();
  sts_chan_if #(.WIDTH(OUT_W)) out_chan ();

  sphere_triangle_subdivide DUT (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #2 clk = ~clk;

  vertex_t pending_vertices[$];
  longint radius = 65536;
  logic [IB-1:0] vertex_counter = '0;
  int errors = 0;
  int idle_cycles = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint floor_sqrt(longint q);
    longint r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'sd1 << b);
      if (c * c <= q) r = c;
    end
    return r;
  endfunction

  // Sums stay within 25 bits, so the square sum and |s|*R fit in 64 bits.
  function automatic point_t sphere_midpoint(point_t a, point_t b);
    point_t o;
    longint s[3], q, len, m, qt, maxp;
    q = 0;
    maxp = (64'sd1 <<< (CB - 1)) - 1;
    for (int i = 0; i < 3; i++) begin
      s[i] = a.c[i] + b.c[i];
      q += s[i] * s[i];
    end
    o.degen = (q == 0);
    if (q == 0) begin
      for (int i = 0; i < 3; i++) o.c[i] = 0;
      return o;
    end
    len = floor_sqrt(q);
    for (int i = 0; i < 3; i++) begin
      m = s[i] < 0 ? -s[i] : s[i];
      qt = (m * radius + (len >>> 1)) / len;
      if (s[i] < 0) o.c[i] = (qt > maxp + 1) ? -(maxp + 1) : -qt;
      else o.c[i] = (qt > maxp) ? maxp : qt;
    end
    return o;
  endfunction

  task automatic predict_subdivision(logic [IN_W-1:0] beat);
    point_t v[3], m12, m23, m13, order[12];
    vertex_t e;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++)
        v[i].c[k] = longint'($signed(beat[IN_W-1-(3*i+k)*CB -: CB]));
      v[i].degen = 1'b0;
    end
    if (beat[0]) vertex_counter = '0;
    m12 = sphere_midpoint(v[0], v[1]);
    m23 = sphere_midpoint(v[1], v[2]);
    m13 = sphere_midpoint(v[0], v[2]);
    order = '{v[0], m12, m13, m12, v[1], m23, m12, m23, m13, m13, m23, v[2]};
    for (int k = 0; k < sts_pkg::VERTS_OUT; k++) begin
      e.x = order[k].c[0][CB-1:0];
      e.y = order[k].c[1][CB-1:0];
      e.z = order[k].c[2][CB-1:0];
      e.number = vertex_counter;
      e.last = (k == sts_pkg::VERTS_OUT - 1);
      e.degen = order[k].degen;
      pending_vertices = {pending_vertices, e};
      vertex_counter = vertex_counter + 1'b1;
    end
  endtask

  task automatic send_triangle(logic [CB-1:0] c[9], bit restart);
    logic [IN_W-1:0] beat;
    int g;
    for (int i = 0; i < 9; i++) beat[IN_W-1-i*CB -: CB] = c[i];
    beat[0] = restart;
    g = gap_len();
    repeat (g + 1) @(negedge clk);
    in_chan.valid <= 1'b1;
    in_chan.data <= beat;
    do @(posedge clk); while (!in_chan.ready);
    predict_subdivision(beat);
    @(negedge clk);
    in_chan.valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (!rst_n) out_chan.ready <= 1'b0;
    else out_chan.ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 99) < 40);
  end

  always @(posedge clk) begin
    vertex_t got, want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = out_chan.data;
      if (pending_vertices.size() == 0) begin
        $error("unexpected vertex beat %h", got);
        errors++;
      end else begin
        want = pending_vertices.pop_front();
        if (got.x !== want.x) begin $error("out_x exp %0d got %0d", want.x, got.x); errors++; end
        if (got.y !== want.y) begin $error("out_y exp %0d got %0d", want.y, got.y); errors++; end
        if (got.z !== want.z) begin $error("out_z exp %0d got %0d", want.z, got.z); errors++; end
        if (got.number !== want.number) begin
          $error("vertex_number exp %0d got %0d", want.number, got.number); errors++;
        end
        if (got.last !== want.last) begin
          $error("last_of_triangle exp %0d got %0d", want.last, got.last); errors++;
        end
        if (got.degen !== want.degen) begin
          $error("degenerate exp %0d got %0d", want.degen, got.degen); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic drain_results();
    while (pending_vertices.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_radius(logic [31:0] value);
    drain_results();
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {1'b0, sts_pkg::REG_SPHERE_RADIUS}; cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    radius = longint'(value[sts_pkg::RADIUS_BITS-1:0]);
  endtask

  function automatic logic [CB-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(CB-1){1'b1}}};
      1: return {1'b1, {(CB-1){1'b0}}};
      2: return CB'($signed($urandom_range(0, 2 * 65536 * 3)) - 65536 * 3);
      default: return CB'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [CB-1:0] c[9];
    logic [CB-1:0] maxp, minn;
    maxp = {1'b0, {(CB-1){1'b1}}};
    minn = {1'b1, {(CB-1){1'b0}}};
    c = '{CB'(65536), '0, '0, '0, CB'(65536), '0, '0, '0, CB'(65536)};
    send_triangle(c, 1'b1);
    c = '{maxp, maxp, maxp, maxp, maxp, maxp, maxp, maxp, maxp};
    send_triangle(c, 1'b0);
    c = '{minn, minn, minn, minn, minn, minn, minn, minn, minn};
    send_triangle(c, 1'b0);
    // Opposite vertices give zero-length edge sums.
    c = '{CB'(1000), CB'(-5), '0, CB'(-1000), CB'(5), '0, CB'(1000), CB'(-5), '0};
    send_triangle(c, 1'b0);
    c = '{default: '0};
    send_triangle(c, 1'b0);
    c = '{maxp, '0, minn, minn, maxp, '0, CB'(1), CB'(-1), maxp};
    send_triangle(c, 1'b1);
    c = '{CB'(1), '0, '0, '0, CB'(-1), '0, '0, '0, CB'(1)};
    send_triangle(c, 1'b0);
  endtask

  task automatic test_random(int count);
    logic [CB-1:0] c[9];
    for (int n = 0; n < count; n++) begin
      foreach (c[i]) c[i] = rand_coord();
      if ($urandom_range(0, 19) == 0) begin
        for (int i = 0; i < 3; i++) c[3 + i] = -c[i];
      end
      send_triangle(c, $urandom_range(0, 9) == 0);
    end
  endtask

  // Enough triangles without restart to wrap the 20-bit counter are too many,
  // so the wrap is only reached if the counter happens to run that far.
  task automatic test_radius_settings();
    write_radius(32'd0);
    test_random(15);
    write_radius(32'h007F_FFFF);
    test_random(15);
    write_radius(32'hFF80_0001);
    test_random(10);
    write_radius(32'd131072);
    test_random(40);
    drain_results();
    test_random(40);
    write_radius(32'd65536);
    test_random(80);
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_radius_settings();
    drain_results();
    if (errors == 0 && pending_vertices.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
